### sv/stable_priority_queue_macros.svh
// assertion helpers shared by the queue files
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SPQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/spq_pkg.sv
package spq_pkg;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_SERVE  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_SERVED   = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_INSERTED = 2'd2,
        ST_DROPPED  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  urgency;
        logic [15:0] patient_id;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] patient_id;
        logic [7:0]  urgency;
    } spq_in_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] served_id;
    } spq_out_t;

    // broadcast to every cell in the chain
    typedef struct packed {
        logic   insert;
        logic   serve;
        entry_t new_entry;
    } spq_ctrl_t;

endpackage

### sv/stable_priority_queue.sv
// Stable priority queue built as a chain of compare-and-shift cells.
// Input channel s_*: one request per transaction, insert (kind 0, with an
// identifier and an urgency) or serve (kind 1). Output channel m_*: exactly
// one result per request, status plus the served identifier.
// Every cell compares its urgency with the new one in parallel, so an insert
// or a serve updates the whole chain at once; the result is registered and
// appears in the cycle after acceptance.
// Throughput is one transaction per cycle: s_ready is high whenever the
// output register is empty or being taken in the same cycle. If the receiver
// holds m_ready low, the pending result stays and s_ready drops until it
// leaves; the chain itself never stalls.
// Equal urgencies are served in arrival order. An insert into a full queue is
// dropped (status 3) and a serve on an empty queue reports status 1.
// Synchronous reset (aresetn low) empties the queue and the output register;
// the queue is usable as soon as reset is released.
`include "stable_priority_queue_macros.svh"

module stable_priority_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  spq_pkg::spq_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output spq_pkg::spq_out_t m_data
);
    import spq_pkg::*;

    entry_t    entry_w [QUEUE_DEPTH];
    logic      valid_w [QUEUE_DEPTH];
    logic      keep_w  [QUEUE_DEPTH];
    spq_ctrl_t ctrl;
    logic      accept, full, empty;
    spq_out_t  result;
    logic      m_valid_reg, m_valid_next;
    spq_out_t  m_data_reg, m_data_next;

    assign full    = valid_w[QUEUE_DEPTH-1];
    assign empty   = !valid_w[0];
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        ctrl.insert               = accept && (s_data.kind == KIND_INSERT) && !full;
        ctrl.serve                = accept && (s_data.kind == KIND_SERVE) && !empty;
        ctrl.new_entry.urgency    = s_data.urgency;
        ctrl.new_entry.patient_id = s_data.patient_id;
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            entry_t left_entry, right_entry;
            logic   left_valid, left_keep, right_valid;
            if (i == 0) begin : g_head
                // the head sees a full-urgency occupant ahead of it
                assign left_entry  = '{urgency: 8'hFF, patient_id: 16'h0000};
                assign left_valid  = 1'b1;
                assign left_keep   = 1'b1;
            end else begin : g_body
                assign left_entry  = entry_w[i-1];
                assign left_valid  = valid_w[i-1];
                assign left_keep   = keep_w[i-1];
            end
            if (i == QUEUE_DEPTH-1) begin : g_tail
                assign right_entry = '0;
                assign right_valid = 1'b0;
            end else begin : g_inner
                assign right_entry = entry_w[i+1];
                assign right_valid = valid_w[i+1];
            end
            spq_cell u_cell (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .ctrl_i        (ctrl),
                .left_entry_i  (left_entry),
                .left_valid_i  (left_valid),
                .left_keep_i   (left_keep),
                .right_entry_i (right_entry),
                .right_valid_i (right_valid),
                .entry_o       (entry_w[i]),
                .valid_o       (valid_w[i]),
                .keep_o        (keep_w[i])
            );
        end
    endgenerate

    always_comb begin
        result.served_id = 16'h0000;
        unique case (s_data.kind)
            KIND_INSERT: begin
                result.status = full ? ST_DROPPED : ST_INSERTED;
            end
            KIND_SERVE: begin
                if (empty) begin
                    result.status = ST_EMPTY;
                end else begin
                    result.status    = ST_SERVED;
                    result.served_id = entry_w[0].patient_id;
                end
            end
            default: begin
                result.status = ST_EMPTY;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        priority if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = result;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SPQ_ASSERT_NXT(a_serve_empty, aclk, aresetn,
        accept && (s_data.kind == KIND_SERVE) && empty,
        m_valid && (m_data.status == ST_EMPTY), "serve on empty queue not reported")
    `SPQ_ASSERT_NXT(a_insert_full, aclk, aresetn,
        accept && (s_data.kind == KIND_INSERT) && full,
        m_valid && (m_data.status == ST_DROPPED) && full, "insert into full queue not dropped")
    `SPQ_ASSERT_IMP(a_id_zero, aclk, aresetn, m_valid && (m_data.status != ST_SERVED),
        m_data.served_id == 16'h0000, "identifier on a non-serve result")

endmodule

### sv/spq_cell.sv
`include "stable_priority_queue_macros.svh"

module spq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_pkg::spq_ctrl_t ctrl_i,
    input  spq_pkg::entry_t    left_entry_i,
    input  logic               left_valid_i,
    input  logic               left_keep_i,
    input  spq_pkg::entry_t    right_entry_i,
    input  logic               right_valid_i,
    output spq_pkg::entry_t    entry_o,
    output logic               valid_o,
    output logic               keep_o
);
    import spq_pkg::*;

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;
    logic   keep;

    // entry stays put on insert when it outranks or ties the newcomer
    assign keep = valid_reg && (entry_reg.urgency >= ctrl_i.new_entry.urgency);

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        priority if (ctrl_i.insert) begin
            if (!keep) begin
                entry_next = left_keep_i ? ctrl_i.new_entry : left_entry_i;
                valid_next = left_valid_i;
            end
        end else if (ctrl_i.serve) begin
            entry_next = right_entry_i;
            valid_next = right_valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign entry_o = entry_reg;
    assign valid_o = valid_reg;
    assign keep_o  = keep;

    `SPQ_ASSERT_IMP(a_occupied_prefix, aclk, aresetn, valid_reg, left_valid_i,
        "occupied cell behind an empty one")
    `SPQ_ASSERT_IMP(a_sorted, aclk, aresetn, valid_reg && left_valid_i,
        left_entry_i.urgency >= entry_reg.urgency, "queue order broken")
    `SPQ_ASSERT_NXT(a_keep_holds, aclk, aresetn, ctrl_i.insert && keep,
        $stable(entry_reg) && valid_reg, "kept entry moved on insert")

endmodule

### verif/stable_priority_queue_tb.sv
`timescale 1ns / 1ps

import spq_pkg::*;

// tracks what the queue should hold and which results are owed
class spq_scoreboard;
    int depth;
    entry_t waiting_line[$];       // index 0 is the head, falling urgency
    spq_out_t owed_results[$];
    int mismatches;

    function new(int d);
        depth = d;
        mismatches = 0;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    task report(string what);
        $display("%0t ns: %s", $time, what);
        mismatches++;
    endtask

    // called for every input transaction that the queue takes
    function void note_request(spq_in_t req);
        spq_out_t res;
        entry_t head;
        entry_t fresh;
        int pos;
        res.status = ST_EMPTY;
        res.served_id = '0;
        if (req.kind == KIND_SERVE) begin
            if (waiting_line.size() != 0) begin
                head = waiting_line.pop_front();
                res.status = ST_SERVED;
                res.served_id = head.patient_id;
            end
        end else if (waiting_line.size() >= depth) begin
            res.status = ST_DROPPED;
        end else begin
            // new entry goes behind everything of equal or higher urgency
            pos = 0;
            while (pos < waiting_line.size() && waiting_line[pos].urgency >= req.urgency)
                pos++;
            fresh.urgency = req.urgency;
            fresh.patient_id = req.patient_id;
            waiting_line.insert(pos, fresh);
            res.status = ST_INSERTED;
        end
        owed_results.push_back(res);
    endfunction

    task check_result(spq_out_t got);
        spq_out_t want;
        if (owed_results.size() == 0) begin
            report($sformatf("unexpected result status %0d id %h", got.status, got.served_id));
        end else begin
            want = owed_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.served_id !== want.served_id)
                report($sformatf("served_id %h, wanted %h", got.served_id, want.served_id));
        end
    endtask
endclass

module stable_priority_queue_tb;

    localparam int QUEUE_DEPTH = 64;
    localparam int REQUEST_TARGET = 1650;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    spq_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    spq_out_t m_data;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int sent_count = 0;

    spq_scoreboard sb = new(QUEUE_DEPTH);

    stable_priority_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(spq_in_t req);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
        sent_count++;
        @(negedge aclk);
    endtask

    task automatic send_fields(kind_t k, logic [15:0] id, logic [7:0] urg);
        spq_in_t req;
        req.kind = k;
        req.patient_id = id;
        req.urgency = urg;
        send_request(req);
    endtask

    // hold the sender off until the queue has answered everything
    task automatic drain_results();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic spq_in_t random_request(int insert_pct, bit tie_heavy);
        spq_in_t req;
        req.kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_SERVE;
        req.patient_id = 16'($urandom);
        if (!tie_heavy)
            req.urgency = 8'($urandom);
        else if ($urandom_range(0, 3) == 0)
            req.urgency = $urandom_range(0, 1) ? 8'hff : 8'h00;
        else
            req.urgency = 8'($urandom_range(120, 124));   // narrow band, lots of ties
        return req;
    endfunction

    // receiver: draw a stall per result, then hold ready until one leaves
    initial begin
        int gap;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, 15) : 0;
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    initial begin
        int seg_len;
        int insert_pct;
        bit tie_heavy;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty serve, field extremes, equal urgencies in order
        send_fields(KIND_SERVE,  16'hffff, 8'hff);
        send_fields(KIND_INSERT, 16'hffff, 8'h00);
        send_fields(KIND_INSERT, 16'h0000, 8'hff);
        send_fields(KIND_INSERT, 16'h1111, 8'h80);
        send_fields(KIND_INSERT, 16'h2222, 8'h80);
        send_fields(KIND_INSERT, 16'h3333, 8'hff);
        send_fields(KIND_INSERT, 16'h4444, 8'h00);
        send_fields(KIND_INSERT, 16'h5555, 8'h80);
        repeat (7) send_fields(KIND_SERVE, 16'h0000, 8'h00);
        send_fields(KIND_SERVE, 16'ha5a5, 8'h5a);
        drain_results();

        // random segments: filling, balanced and draining phases
        while (sent_count < REQUEST_TARGET) begin
            seg_len = $urandom_range(20, 120);
            case ($urandom_range(0, 3))
                0: insert_pct = 92;
                1: insert_pct = 50;
                2: insert_pct = 12;
                default: insert_pct = 70;
            endcase
            tie_heavy = 1'($urandom_range(0, 1));
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            repeat (seg_len) send_request(random_request(insert_pct, tie_heavy));
            if ($urandom_range(0, 3) == 0)
                drain_results();
        end

        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
